/* rtl/lsme_pkg.sv */
// shared types, widths and codes for the lsb stego message extractor
`default_nettype none
package lsme_pkg;

  localparam int PIXEL_W      = 24;
  localparam int VALUE_W      = 32;
  localparam int KIND_W       = 2;
  localparam int SIZE_BITS_DEF = 32;
  localparam int QUEUE_DEPTH  = 4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_NAME = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SIZE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATA = 2'd2;

  // channel rotation codes
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // last bit index of a byte word
  localparam logic [4:0] BYTE_LAST = 5'd7;

  // one decoded pixel as passed from front to back
  typedef struct packed {
    logic restart;
    logic data_bit;
  } beat_t;

endpackage
`default_nettype wire

/* rtl/lsb_stego_message_extractor.sv */
// top level of the lsb stego message extractor
//
//  channel | ports          | tdata                 | tuser          | tlast
//  in      | in_t*          | pixel_rgb [23:0]      | first_pixel    | -
//  out     | out_t*         | value [31:0]          | kind [1:0]     | last
//
// one pixel per cycle while the bit queue has room; a result passes through the queue
// write, then the output register of the back end
// the four-entry bit queue lets the front keep taking pixels while a result waits
// reset clears channel rotation, queue pointers, phase, counters and output valid
// pixels in the idle phase are taken and dropped until first_pixel restarts decoding
`default_nettype none
module lsb_stego_message_extractor #(
  parameter int SIZE_BITS = lsme_pkg::SIZE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [lsme_pkg::PIXEL_W-1:0]      in_tdata,   // pixel_rgb
  input  wire logic                              in_tuser,   // first_pixel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [lsme_pkg::VALUE_W-1:0]           out_tdata,  // value
  output logic [lsme_pkg::KIND_W-1:0]            out_tuser,  // kind
  output logic                                   out_tlast
);

  lsme_pkg::beat_t front_beat;
  lsme_pkg::beat_t back_beat;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  logic            in_fire;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  lsme_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (in_fire),
    .pix_rgb   (in_tdata),
    .pix_first (in_tuser),
    .beat      (front_beat)
  );

  lsme_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_beat (front_beat),
    .full      (q_full),
    .pop       (q_pop),
    .pop_beat  (back_beat),
    .empty     (q_empty)
  );

  lsme_back #(
    .SIZE_BITS (SIZE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_empty),
    .q_beat    (back_beat),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_value (out_tdata),
    .out_last  (out_tlast)
  );

endmodule
`default_nettype wire

/* rtl/lsme_front.sv */
// front end: picks the hidden bit of each pixel, rotating red, green, blue
`default_nettype none
module lsme_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          pix_valid,
  input  wire logic [lsme_pkg::PIXEL_W-1:0]  pix_rgb,
  input  wire logic                          pix_first,
  output lsme_pkg::beat_t                    beat
);

  logic [1:0] ch_r;
  logic [1:0] ch_nxt;
  logic [1:0] ch_cur;

  always_comb begin
    ch_cur = pix_first ? lsme_pkg::CH_RED : ch_r;
    beat.restart = pix_first;
    case (ch_cur)
      lsme_pkg::CH_GREEN: beat.data_bit = pix_rgb[8];
      lsme_pkg::CH_BLUE:  beat.data_bit = pix_rgb[0];
      default:            beat.data_bit = pix_rgb[16];
    endcase
    // unused code 3 acts as red, so it moves on to green
    case (ch_cur)
      lsme_pkg::CH_GREEN: ch_nxt = lsme_pkg::CH_BLUE;
      lsme_pkg::CH_BLUE:  ch_nxt = lsme_pkg::CH_RED;
      default:            ch_nxt = lsme_pkg::CH_GREEN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= lsme_pkg::CH_RED;
    end else if (pix_valid) begin
      ch_r <= ch_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/lsme_queue.sv */
// short queue of decoded bits between front and back
`default_nettype none
module lsme_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire lsme_pkg::beat_t push_beat,
  output logic                 full,
  input  wire logic            pop,
  output lsme_pkg::beat_t      pop_beat,
  output logic                 empty
);

  localparam int PTR_W = $clog2(lsme_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(lsme_pkg::QUEUE_DEPTH + 1);

  lsme_pkg::beat_t mem [lsme_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full     = (count_r == CNT_W'(lsme_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_beat = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(lsme_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(lsme_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full && !pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("queue pop while empty");

endmodule
`default_nettype wire

/* rtl/lsme_back.sv */
// back end: assembles bits into words, walks name, size and payload phases
`default_nettype none
module lsme_back #(
  parameter int SIZE_BITS = lsme_pkg::SIZE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire lsme_pkg::beat_t               q_beat,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lsme_pkg::KIND_W-1:0]        out_kind,
  output logic [lsme_pkg::VALUE_W-1:0]       out_value,
  output logic                               out_last
);

  typedef enum logic [1:0] {
    PH_NAME = 2'd0,
    PH_SIZE = 2'd1,
    PH_DATA = 2'd2,
    PH_IDLE = 2'd3
  } phase_t;

  localparam logic [4:0] SIZE_LAST = 5'(SIZE_BITS - 1);

  phase_t                        phase_r, phase_nxt, ph;
  logic [4:0]                    bit_cnt_r, bit_cnt_nxt, bc;
  logic [SIZE_BITS-1:0]          shift_r, shift_nxt, sh, sh_new;
  logic [SIZE_BITS-1:0]          left_r, left_nxt, bl, bl_dec;
  logic [4:0]                    need_last;
  logic                          emit;
  logic [lsme_pkg::KIND_W-1:0]   kind_nxt;
  logic [lsme_pkg::VALUE_W-1:0]  value_nxt;
  logic                          last_nxt;
  logic                          out_valid_r;
  logic [lsme_pkg::KIND_W-1:0]   kind_r;
  logic [lsme_pkg::VALUE_W-1:0]  value_r;
  logic                          last_r;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_value = value_r;
  assign out_last  = last_r;

  always_comb begin
    // a restart beat starts from the reset state
    ph = q_beat.restart ? PH_NAME : phase_r;
    bc = q_beat.restart ? '0 : bit_cnt_r;
    sh = q_beat.restart ? '0 : shift_r;
    bl = q_beat.restart ? '0 : left_r;

    sh_new    = {sh[SIZE_BITS-2:0], q_beat.data_bit};
    bl_dec    = bl - 1'b1;
    need_last = (ph == PH_SIZE) ? SIZE_LAST : lsme_pkg::BYTE_LAST;

    phase_nxt   = ph;
    bit_cnt_nxt = bc;
    shift_nxt   = sh;
    left_nxt    = bl;
    emit        = 1'b0;
    kind_nxt    = lsme_pkg::KIND_NAME;
    value_nxt   = lsme_pkg::VALUE_W'(sh_new[7:0]);
    last_nxt    = 1'b0;

    if (ph != PH_IDLE) begin
      if (bc < need_last) begin
        bit_cnt_nxt = bc + 1'b1;
        shift_nxt   = sh_new;
      end else begin
        bit_cnt_nxt = '0;
        shift_nxt   = '0;
        case (ph)
          PH_NAME: begin
            // zero byte ends the name and is not emitted
            if (sh_new[7:0] == 8'd0) begin
              phase_nxt = PH_SIZE;
            end else begin
              emit = 1'b1;
            end
          end
          PH_SIZE: begin
            emit      = 1'b1;
            kind_nxt  = lsme_pkg::KIND_SIZE;
            value_nxt = lsme_pkg::VALUE_W'(sh_new);
            left_nxt  = sh_new;
            last_nxt  = (sh_new == '0);
            phase_nxt = (sh_new == '0) ? PH_IDLE : PH_DATA;
          end
          default: begin
            emit      = 1'b1;
            kind_nxt  = lsme_pkg::KIND_DATA;
            left_nxt  = bl_dec;
            last_nxt  = (bl_dec == '0);
            phase_nxt = (bl_dec == '0) ? PH_IDLE : PH_DATA;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_NAME;
      bit_cnt_r   <= '0;
      shift_r     <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a pop only happens once the held beat is gone or leaving
      out_valid_r <= q_pop ? emit : (out_valid_r && !out_ready);
      if (q_pop) begin
        phase_r   <= phase_nxt;
        bit_cnt_r <= bit_cnt_nxt;
        shift_r   <= shift_nxt;
        left_r    <= left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
      last_r  <= last_nxt;
    end
  end

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r |-> (kind_r == lsme_pkg::KIND_NAME || kind_r == lsme_pkg::KIND_SIZE ||
                       kind_r == lsme_pkg::KIND_DATA))
    else $error("result kind out of range");
  a_name_not_last: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && kind_r == lsme_pkg::KIND_NAME) |-> !last_r)
    else $error("name character marked last");
  a_byte_fits: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && kind_r != lsme_pkg::KIND_SIZE) |-> (value_r[31:8] == 24'd0))
    else $error("byte result wider than eight bits");
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
      (q_pop && !q_beat.restart && phase_r == PH_IDLE) |=> (phase_r == PH_IDLE))
    else $error("idle left without restart");

endmodule
`default_nettype wire

/* sim/msg_decode_checker.sv */
// scoreboard for the lsb stego message extractor: decodes accepted pixels and checks each result
`timescale 1ns / 1ps
module msg_decode_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  input  wire logic                          in_tready,
  input  wire logic [lsme_pkg::PIXEL_W-1:0]  in_tdata,   // pixel_rgb
  input  wire logic                          in_tuser,   // first_pixel
  input  wire logic                          out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic [lsme_pkg::VALUE_W-1:0]  out_tdata,  // value
  input  wire logic [lsme_pkg::KIND_W-1:0]   out_tuser,  // kind
  input  wire logic                          out_tlast,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 checked
);
  import lsme_pkg::*;

  typedef enum logic [1:0] {PH_NAME, PH_SIZE, PH_DATA, PH_IDLE} decode_phase_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic               last;
  } msg_result_t;

  // decoder state
  logic [1:0]         chan;
  logic [4:0]         nbits;
  logic [VALUE_W-1:0] shreg;
  decode_phase_t      ph;
  logic [31:0]        bytes_left;

  msg_result_t predicted_words[$];
  int          n_fail;
  int          n_checked;

  function automatic void clear_decoder();
    chan       = CH_RED;
    nbits      = '0;
    shreg      = '0;
    ph         = PH_NAME;
    bytes_left = '0;
  endfunction

  // returns 1 when the pixel completes a result
  function automatic bit decode_pixel(input logic [PIXEL_W-1:0] pix, input logic restart,
                                      output msg_result_t res);
    logic        lsb;
    int          need;
    logic [63:0] word;
    res = '0;
    if (restart) clear_decoder();
    if (ph == PH_IDLE) return 1'b0;
    if (chan > CH_BLUE) chan = CH_RED;
    case (chan)
      CH_GREEN: lsb = pix[8];
      CH_BLUE:  lsb = pix[0];
      default:  lsb = pix[16];
    endcase
    shreg = {shreg[VALUE_W-2:0], lsb};
    chan  = (chan == CH_BLUE) ? CH_RED : chan + 2'd1;
    need  = (ph == PH_SIZE) ? SIZE_BITS_DEF : 8;
    if (int'(nbits) + 1 < need) begin
      nbits = nbits + 5'd1;
      return 1'b0;
    end
    nbits = '0;
    word  = {32'b0, shreg} & ((64'd1 << need) - 64'd1);
    shreg = '0;
    case (ph)
      PH_NAME: begin
        // terminating zero byte ends the name silently
        if (word == 64'd0) begin
          ph = PH_SIZE;
          return 1'b0;
        end
        res.kind  = KIND_NAME;
        res.value = word[31:0];
        res.last  = 1'b0;
      end
      PH_SIZE: begin
        bytes_left = word[31:0];
        res.kind   = KIND_SIZE;
        res.value  = word[31:0];
        res.last   = (word == 64'd0);
        ph         = (word == 64'd0) ? PH_IDLE : PH_DATA;
      end
      default: begin
        bytes_left = bytes_left - 32'd1;
        res.kind   = KIND_DATA;
        res.value  = word[31:0];
        res.last   = (bytes_left == 32'd0);
        if (bytes_left == 32'd0) ph = PH_IDLE;
      end
    endcase
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    msg_result_t got;
    msg_result_t want;
    msg_result_t res;
    if (!rst_n) begin
      clear_decoder();
      predicted_words.delete();
      n_fail    = 0;
      n_checked = 0;
    end else begin
      // result side first: nothing accepted now can come from this edge's pixel
      if (out_tvalid && out_tready) begin
        got.kind  = out_tuser;
        got.value = out_tdata;
        got.last  = out_tlast;
        if (predicted_words.size() == 0) begin
          $display("%0t: unexpected result kind %0d value %h last %b",
                   $time, got.kind, got.value, got.last);
          n_fail++;
        end else begin
          want = predicted_words.pop_front();
          n_checked++;
          if (got.kind !== want.kind) begin
            $display("%0t: kind mismatch expected %0d actual %0d", $time, want.kind, got.kind);
            n_fail++;
          end
          if (got.value !== want.value) begin
            $display("%0t: value mismatch expected %h actual %h", $time, want.value, got.value);
            n_fail++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last mismatch expected %b actual %b", $time, want.last, got.last);
            n_fail++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (decode_pixel(in_tdata, in_tuser, res)) predicted_words.push_back(res);
      end
    end
    fail_count <= n_fail;
    pending    <= predicted_words.size();
    checked    <= n_checked;
  end

endmodule

/* sim/testbench.sv */
// top of the testbench: clock, reset, pixel stimulus, result stalls and the verdict
`timescale 1ns / 1ps
module testbench;
  import lsme_pkg::*;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [PIXEL_W-1:0]  in_tdata   = '0;   // pixel_rgb
  logic                in_tuser   = 1'b0; // first_pixel
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [VALUE_W-1:0]  out_tdata;         // value
  logic [KIND_W-1:0]   out_tuser;         // kind
  logic                out_tlast;

  int fail_count;
  int pending;
  int checked;

  bit no_idle = 1'b0;
  bit msg_bits[$];
  int items    = 0;
  int n_msgs   = 0;
  int n_broken = 0;
  int n_noise  = 0;

  always #1 clk = ~clk;

  lsb_stego_message_extractor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  msg_decode_checker decode_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= 28);
    end
  end

  task automatic put_pixel(input logic [PIXEL_W-1:0] pix, input logic first);
    while (!no_idle && $urandom_range(99) < 28) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic push_bits(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) msg_bits.push_back(v[i]);
  endtask

  // name of nonzero characters, terminator, size word, payload
  task automatic build_message(input int name_len, input logic [31:0] size_word,
                               input int pay_len);
    msg_bits.delete();
    repeat (name_len) push_bits($urandom_range(255, 1), 8);
    push_bits(32'd0, 8);
    push_bits(size_word, SIZE_BITS_DEF);
    repeat (pay_len) push_bits($urandom_range(255), 8);
  endtask

  // hide message bits in the rotating channel lsb, restarting on the first beat
  task automatic send_bits(input int upto, input bit plain);
    logic [PIXEL_W-1:0] pix;
    logic [1:0]         ch;
    ch = CH_RED;
    n_msgs++;
    for (int i = 0; i < upto && i < msg_bits.size(); i++) begin
      pix = plain ? {PIXEL_W{msg_bits[i]}} : PIXEL_W'($urandom_range(32'hFF_FFFF));
      case (ch)
        CH_GREEN: pix[8]  = msg_bits[i];
        CH_BLUE:  pix[0]  = msg_bits[i];
        default:  pix[16] = msg_bits[i];
      endcase
      put_pixel(pix, i == 0);
      ch = (ch == CH_BLUE) ? CH_RED : ch + 2'd1;
      items++;
    end
  endtask

  // pixels after the message ends are dropped by the block
  task automatic send_idle(input int n);
    repeat (n) begin
      put_pixel(PIXEL_W'($urandom_range(32'hFF_FFFF)), 1'b0);
      items++;
    end
  endtask

  task automatic send_noise(input int n);
    n_noise++;
    repeat (n) begin
      put_pixel(PIXEL_W'($urandom_range(32'hFF_FFFF)), $urandom_range(19) == 0);
      items++;
    end
  endtask

  task automatic wait_drained();
    // take the last beat off the bus so it is not sent again while waiting
    if (in_tvalid) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int          roll;
    int          name_len;
    int          pay_len;
    logic [31:0] size_word;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty name, zero size, pixels all zeros or all ones, then ignored pixels
    build_message(0, 32'd0, 0);
    send_bits(msg_bits.size(), 1'b1);
    send_idle(6);

    // extreme name and payload bytes
    msg_bits.delete();
    push_bits(8'h01, 8);
    push_bits(8'hFF, 8);
    push_bits(8'h00, 8);
    push_bits(32'd3, SIZE_BITS_DEF);
    push_bits(8'h00, 8);
    push_bits(8'hFF, 8);
    push_bits(8'h5A, 8);
    send_bits(msg_bits.size(), 1'b0);
    send_idle(3);

    // long name
    build_message(40, 32'd1, 1);
    send_bits(msg_bits.size(), 1'b0);

    // largest size, cut short by a restart
    build_message(1, 32'hFFFF_FFFF, 2);
    send_bits(msg_bits.size(), 1'b0);
    n_broken++;

    // restart in the middle of the name
    build_message(4, 32'd5, 5);
    send_bits(13, 1'b0);
    n_broken++;

    build_message(2, 32'd2, 2);
    send_bits(msg_bits.size(), 1'b0);
    wait_drained();

    while (items < 1150) begin
      no_idle <= (items >= 400 && items < 650);
      roll     = $urandom_range(99);
      name_len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(5);
      if (roll < 10) begin
        send_noise($urandom_range(80, 10));
      end else begin
        case ($urandom_range(19))
          0, 1:    size_word = 32'd0;
          2:       size_word = ($urandom_range(1)) ? 32'hFFFF_FFFF : $urandom;
          default: size_word = $urandom_range(12, 1);
        endcase
        pay_len = (size_word > 32'd12) ? $urandom_range(3) : int'(size_word);
        build_message(name_len, size_word, pay_len);
        if (roll < 20 || size_word > 32'd12) begin
          send_bits($urandom_range(msg_bits.size() - 1, 1), 1'b0);
          n_broken++;
        end else begin
          send_bits(msg_bits.size(), 1'b0);
          if ($urandom_range(1)) send_idle($urandom_range(4));
        end
      end
      if ($urandom_range(5) == 0) wait_drained();
    end

    wait_drained();
    // results pass through the queue and the output register; give stragglers time to show
    repeat (10) @(posedge clk);
    $display("covered %0d messages (%0d cut short) and %0d noise bursts: %0d pixels",
             n_msgs, n_broken, n_noise, items);
    $display("%0d results checked", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results outstanding", pending);
    $display("testbench: FAIL");
    $finish;
  end

endmodule
